FILE: sv/tilt_packet_check_and_scale_unit_assert.svh
// Assertion macros shared by the tilt packet checker RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef TILT_PACKET_CHECK_AND_SCALE_UNIT_ASSERT_SVH
`define TILT_PACKET_CHECK_AND_SCALE_UNIT_ASSERT_SVH

// same-cycle implication
`define TPCS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tpcs check failed");

// next-cycle implication
`define TPCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tpcs check failed");

`endif

FILE: sv/tpcs_pkg.sv
// Types and constants for the tilt packet checker and angle scaler.
// No dependencies; imported by every module of the block.
package tpcs_pkg;

  typedef enum logic [1:0] {
    ST_FAIL = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2,
    ST_CSUM = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_PITCH_BIAS  = 2'd0,
    CFG_ROLL_BIAS   = 2'd1,
    CFG_ERROR_LIMIT = 2'd2
  } cfg_index_e;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [7:0]  HeaderStart = 8'hFF;
  localparam logic [16:0] RawMid      = 17'd32768;
  localparam logic [14:0] Deg90Q8     = 15'd23040;
  localparam logic [14:0] HalfFull    = 15'd16383;
  localparam logic [15:0] RawFull     = 16'd32767;
  localparam logic [18:0] Deg2RadQ24  = 19'd292818;
  localparam int unsigned RadShift    = 19;

  typedef struct packed {
    logic       read_ok;
    logic       full_length;
    logic [7:0] header_byte;
    logic [7:0] pitch_high;
    logic [7:0] pitch_low;
    logic [7:0] roll_high;
    logic [7:0] roll_low;
    logic [7:0] sum_byte;
  } tpcs_in_t;

  typedef struct packed {
    status_e            status;
    logic               reset_request;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } tpcs_out_t;

  // classified request handed from front to back
  typedef struct packed {
    status_e     status;
    logic        reset_request;
    logic [15:0] pitch_raw;
    logic [15:0] roll_raw;
  } tpcs_entry_t;

endpackage

FILE: sv/tilt_packet_check_and_scale_unit.sv
// Top level of the tilt packet checker and angle scaler.
// Depends on tpcs_pkg, tpcs_front, tpcs_fifo and tpcs_back.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    tpcs_in_t   reply bytes and flags
//   out      output     out_valid/out_ready  tpcs_out_t  status and held angles
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// Failed, bad-frame and checksum-mismatch replies are written straight into the
// result register when popped; a good frame runs the scaler sequence (multiply,
// divide, radian multiply, round), and the scaler pops no new entry until it is done.
// The front end takes a new reply every cycle while the queue has room.
// Reset clears the error counter, held angles and queue, and loads the config defaults.
// A stalled output holds its result; the queue fills, then in_ready drops.
module tilt_packet_check_and_scale_unit
  import tpcs_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tpcs_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tpcs_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  logic signed [12:0] pitch_bias_q, roll_bias_q;
  logic [5:0]         error_limit_q;

  logic        push, pop, q_full, q_valid;
  tpcs_entry_t entry_in, entry_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_bias_q  <= -13'sd192;
      roll_bias_q   <= 13'sd38;
      error_limit_q <= 6'd30;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PITCH_BIAS:  pitch_bias_q  <= $signed(cfg_data_i);
        CFG_ROLL_BIAS:   roll_bias_q   <= $signed(cfg_data_i);
        CFG_ERROR_LIMIT: error_limit_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  tpcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .error_limit_i (error_limit_q),
    .q_full_i      (q_full),
    .q_push_o      (push),
    .q_entry_o     (entry_in)
  );

  tpcs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (entry_out)
  );

  tpcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (entry_out),
    .q_pop_o      (pop),
    .pitch_bias_i (pitch_bias_q),
    .roll_bias_i  (roll_bias_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: sv/tpcs_front.sv
// Front end: accepts replies, checks header, length and checksum,
// keeps the bad-reply counter. Depends on tpcs_pkg.
module tpcs_front
  import tpcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tpcs_in_t    in_data_i,
  input  logic [5:0]  error_limit_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output tpcs_entry_t q_entry_o
);

  logic [5:0] bad_count_q, bad_count_d;
  logic [6:0] bad_next;
  logic [7:0] sum8;
  logic       over_limit;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign sum8 = in_data_i.pitch_high + in_data_i.pitch_low
              + in_data_i.roll_high + in_data_i.roll_low;
  assign bad_next   = {1'b0, bad_count_q} + 7'd1;
  assign over_limit = bad_next > {1'b0, error_limit_i};

  always_comb begin
    q_entry_o.status        = ST_FAIL;
    q_entry_o.reset_request = 1'b0;
    q_entry_o.pitch_raw     = {in_data_i.pitch_high, in_data_i.pitch_low};
    q_entry_o.roll_raw      = {in_data_i.roll_high, in_data_i.roll_low};
    bad_count_d             = bad_count_q;
    if (!in_data_i.read_ok) begin
      q_entry_o.status = ST_FAIL;
    end else if (in_data_i.header_byte != HeaderStart || !in_data_i.full_length) begin
      q_entry_o.status = ST_BAD;
      if (over_limit) begin
        q_entry_o.reset_request = 1'b1;
        bad_count_d             = '0;
      end else begin
        bad_count_d = bad_next[5:0];
      end
    end else if (sum8 != in_data_i.sum_byte) begin
      q_entry_o.status = ST_CSUM;
    end else begin
      q_entry_o.status = ST_GOOD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_count_q <= '0;
    end else if (q_push_o) begin
      bad_count_q <= bad_count_d;
    end
  end

endmodule

FILE: sv/tpcs_fifo.sv
// Short request queue between the front end and the scaler.
// Depends on tpcs_pkg for the entry type.
module tpcs_fifo
  import tpcs_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  tpcs_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output tpcs_entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tpcs_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == FullCnt;
  assign valid_o = count_q != '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

FILE: sv/tpcs_back.sv
// Back end: scales raw readings to radians, holds the angles and
// drives the result register. Depends on tpcs_pkg and the assert header.
`include "tilt_packet_check_and_scale_unit_assert.svh"
module tpcs_back
  import tpcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  tpcs_entry_t        q_entry_i,
  output logic               q_pop_o,
  input  logic signed [12:0] pitch_bias_i,
  input  logic signed [12:0] roll_bias_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tpcs_out_t          out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_RAD  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic               out_valid_q;
  tpcs_out_t          out_q;
  logic signed [15:0] pitch_held_q, roll_held_q;

  // step 1: |raw - mid| * 90 deg
  logic signed [16:0] tp, tr;
  logic [15:0]        mag_p, mag_r;
  logic [29:0]        prod_p_q, prod_r_q;
  logic               neg_p_q, neg_r_q;
  // step 2: divide by full scale, add offsets
  logic signed [17:0] deg_p_q, deg_r_q;
  logic signed [17:0] deg_p, deg_r, s_p, s_r;
  // step 3: to radians
  logic [35:0]        rad_p_q, rad_r_q;
  logic               dneg_p_q, dneg_r_q;
  logic [16:0]        dmag_p, dmag_r;
  logic signed [15:0] ang_p, ang_r;
  logic               out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign tp    = $signed({1'b0, q_entry_i.pitch_raw}) - $signed(RawMid);
  assign tr    = $signed({1'b0, q_entry_i.roll_raw}) - $signed(RawMid);
  assign mag_p = tp[16] ? 16'(-tp) : tp[15:0];
  assign mag_r = tr[16] ? 16'(-tr) : tr[15:0];

  // n / 32767 for n < 2^30: q0 = n >> 15 leaves a remainder below twice the divisor
  function automatic logic signed [17:0] div_full(logic [29:0] prod, logic neg);
    logic [29:0] num;
    logic [14:0] q0;
    logic [15:0] rem;
    logic [15:0] q;
    num = prod + 30'(HalfFull);
    q0  = num[29:15];
    rem = {1'b0, num[14:0]} + {1'b0, q0};
    q   = {1'b0, q0} + ((rem >= RawFull) ? 16'd1 : 16'd0);
    return neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
  endfunction

  // round half away from zero, then saturate to 16 bits
  function automatic logic signed [15:0] rad_round(logic [35:0] prod, logic neg);
    logic [35:0] sum;
    logic [16:0] mag;
    sum = prod + (36'd1 << (RadShift - 1));
    mag = sum[RadShift +: 17];
    if (!neg) begin
      return (mag > 17'd32767) ? 16'sd32767 : $signed(mag[15:0]);
    end
    return (mag > 17'd32768) ? 16'sh8000 : $signed(16'(-mag));
  endfunction

  assign s_p   = div_full(prod_p_q, neg_p_q);
  assign s_r   = div_full(prod_r_q, neg_r_q);
  assign deg_p = -$signed({3'b000, Deg90Q8}) - s_p + 18'(pitch_bias_i);
  assign deg_r = $signed({3'b000, Deg90Q8}) + s_r + 18'(roll_bias_i);

  assign dmag_p = deg_p_q[17] ? 17'(-deg_p_q) : deg_p_q[16:0];
  assign dmag_r = deg_r_q[17] ? 17'(-deg_r_q) : deg_r_q[16:0];

  assign ang_p = rad_round(rad_p_q, dneg_p_q);
  assign ang_r = rad_round(rad_r_q, dneg_r_q);

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (q_entry_i.status == ST_GOOD) begin
            q_pop_o = 1'b1;
            state_d = S_DIV;
          end else if (out_free) begin
            q_pop_o = 1'b1;
          end
        end
      end
      S_DIV:  state_d = S_RAD;
      S_RAD:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      pitch_held_q <= '0;
      roll_held_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && q_pop_o && q_entry_i.status != ST_GOOD) begin
        out_valid_q <= 1'b1;
      end else if (state_q == S_DONE && out_free) begin
        out_valid_q  <= 1'b1;
        pitch_held_q <= ang_p;
        roll_held_q  <= ang_r;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_pop_o) begin
      prod_p_q <= 30'(mag_p) * 30'(Deg90Q8);
      prod_r_q <= 30'(mag_r) * 30'(Deg90Q8);
      neg_p_q  <= tp[16];
      neg_r_q  <= tr[16];
      if (q_entry_i.status != ST_GOOD) begin
        out_q.status        <= q_entry_i.status;
        out_q.reset_request <= q_entry_i.reset_request;
        out_q.pitch_angle   <= pitch_held_q;
        out_q.roll_angle    <= roll_held_q;
      end
    end
    if (state_q == S_DIV) begin
      deg_p_q <= deg_p;
      deg_r_q <= deg_r;
    end
    if (state_q == S_RAD) begin
      rad_p_q  <= 36'(dmag_p) * 36'(Deg2RadQ24);
      rad_r_q  <= 36'(dmag_r) * 36'(Deg2RadQ24);
      dneg_p_q <= deg_p_q[17];
      dneg_r_q <= deg_r_q[17];
    end
    if (state_q == S_DONE && out_free) begin
      out_q.status        <= ST_GOOD;
      out_q.reset_request <= 1'b0;
      out_q.pitch_angle   <= ang_p;
      out_q.roll_angle    <= ang_r;
    end
  end

  `TPCS_ASSERT_NOW(a_reset_req_bad, clk_i, rst_ni,
                   out_valid_q && out_q.reset_request, out_q.status == ST_BAD)
  `TPCS_ASSERT_NEXT(a_div_then_rad, clk_i, rst_ni, state_q == S_DIV, state_q == S_RAD)
  `TPCS_ASSERT_NOW(a_held_on_done, clk_i, rst_ni,
                   !$stable(pitch_held_q) || !$stable(roll_held_q),
                   $past(state_q) == S_DONE)

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tilt_packet_check_and_scale_unit.
// Needs tpcs_pkg and the block's RTL; a scoreboard class predicts every reply.

module tb;
  import tpcs_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int HoldCycles    = 300;
  localparam int SettleCycles  = 10;

  // Angle arithmetic: degrees in Q8, radians in Q3.13.
  localparam longint QuarterTurnQ8 = 23040;
  localparam longint RawSpan       = 32767;
  localparam longint RawCenter     = 32768;
  localparam longint DegToRadQ24   = 292818;
  localparam int     RadFracShift  = 19;

  class tilt_scoreboard;
    logic signed [12:0] pitch_bias;
    logic signed [12:0] roll_bias;
    logic [5:0]         err_limit;
    logic [5:0]         bad_count;
    logic signed [15:0] pitch_q13;
    logic signed [15:0] roll_q13;
    tpcs_out_t          pending[$];
    int                 errors;

    function new();
      pitch_bias = -13'sd192;
      roll_bias  = 13'sd38;
      err_limit  = 6'd30;
      bad_count  = '0;
      pitch_q13  = '0;
      roll_q13   = '0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_index_e idx, logic [12:0] val);
      case (idx)
        CFG_PITCH_BIAS:  pitch_bias = val;
        CFG_ROLL_BIAS:   roll_bias  = val;
        CFG_ERROR_LIMIT: err_limit  = val[5:0];
        default: ;
      endcase
    endfunction

    // half away from zero
    function longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    function logic signed [15:0] deg_to_q13(longint deg_q8);
      longint r;
      r = round_div(deg_q8 * DegToRadQ24, longint'(1) << RadFracShift);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void note_request(tpcs_in_t d);
      tpcs_out_t  exp;
      logic [6:0] next_count;
      logic [7:0] sum;
      longint     tp, tr, sp, sr;
      exp.reset_request = 1'b0;
      sum = d.pitch_high + d.pitch_low + d.roll_high + d.roll_low;
      if (!d.read_ok) begin
        exp.status = ST_FAIL;
      end else if (d.header_byte != 8'hFF || !d.full_length) begin
        exp.status = ST_BAD;
        next_count = {1'b0, bad_count} + 7'd1;
        if (next_count > {1'b0, err_limit}) begin
          bad_count = '0;
          exp.reset_request = 1'b1;
        end else begin
          bad_count = next_count[5:0];
        end
      end else if (sum != d.sum_byte) begin
        exp.status = ST_CSUM;
      end else begin
        tp = longint'({d.pitch_high, d.pitch_low}) - RawCenter;
        tr = longint'({d.roll_high, d.roll_low}) - RawCenter;
        sp = round_div(QuarterTurnQ8 * tp, RawSpan);
        sr = round_div(QuarterTurnQ8 * tr, RawSpan);
        pitch_q13 = deg_to_q13(-QuarterTurnQ8 - sp + longint'(pitch_bias));
        roll_q13  = deg_to_q13(QuarterTurnQ8 + sr + longint'(roll_bias));
        exp.status = ST_GOOD;
      end
      exp.pitch_angle = pitch_q13;
      exp.roll_angle  = roll_q13;
      pending.push_back(exp);
    endfunction

    function void check_result(tpcs_out_t got);
      tpcs_out_t exp;
      if (pending.size() == 0) begin
        $error("result with no request pending: status %0d", got.status);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.reset_request !== exp.reset_request) begin
        $error("reset_request: expected %0d, got %0d", exp.reset_request, got.reset_request);
        errors++;
      end
      if (got.pitch_angle !== exp.pitch_angle) begin
        $error("pitch_angle: expected %0d, got %0d", exp.pitch_angle, got.pitch_angle);
        errors++;
      end
      if (got.roll_angle !== exp.roll_angle) begin
        $error("roll_angle: expected %0d, got %0d", exp.roll_angle, got.roll_angle);
        errors++;
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  tpcs_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tpcs_out_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  tilt_scoreboard sb;
  bit             hold_req;
  int             idle_cycles;
  int             burst_left;

  tilt_packet_check_and_scale_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Results are checked before the same edge's request is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_request(in_data);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: rotating stall pattern, reloaded from a random choice of patterns, plus one long hold.
  initial begin
    logic [15:0] stall_pat;
    int          pat_age;
    stall_pat = '1;
    pat_age   = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        pat_age++;
        if (pat_age == 64) begin
          pat_age = 0;
          case ($urandom_range(3))
            0: stall_pat = '1;
            1: stall_pat = 16'($urandom);
            2: stall_pat = 16'($urandom | $urandom);
            default: stall_pat = 16'(($urandom & $urandom) | 32'h0001);
          endcase
        end
      end
    end
  end

  function automatic tpcs_in_t make_frame(bit rok, bit full, logic [7:0] hdr, logic [7:0] ph,
                                          logic [7:0] pl, logic [7:0] rh, logic [7:0] rl,
                                          logic [7:0] sum);
    tpcs_in_t d;
    d.read_ok     = rok;
    d.full_length = full;
    d.header_byte = hdr;
    d.pitch_high  = ph;
    d.pitch_low   = pl;
    d.roll_high   = rh;
    d.roll_low    = rl;
    d.sum_byte    = sum;
    return d;
  endfunction

  function automatic tpcs_in_t good_frame(logic [7:0] ph, logic [7:0] pl, logic [7:0] rh,
                                          logic [7:0] rl);
    logic [7:0] sum;
    sum = ph + pl + rh + rl;
    return make_frame(1'b1, 1'b1, 8'hFF, ph, pl, rh, rl, sum);
  endfunction

  function automatic logic [7:0] data_byte();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: return 8'h00;
        1: return 8'hFF;
        2: return 8'h80;
        default: return 8'h7F;
      endcase
    end
    return 8'($urandom);
  endfunction

  function automatic tpcs_in_t make_reply(int bad_pct);
    tpcs_in_t   d;
    int         pick;
    logic [7:0] hdr;
    d    = good_frame(data_byte(), data_byte(), data_byte(), data_byte());
    pick = $urandom_range(99);
    if (pick < 5) begin
      d.pitch_high  = 8'($urandom);
      d.pitch_low   = 8'($urandom);
      d.roll_high   = 8'($urandom);
      d.roll_low    = 8'($urandom);
      d.sum_byte    = 8'($urandom);
      d.read_ok     = 1'($urandom);
      d.full_length = 1'($urandom);
      d.header_byte = ($urandom_range(1) == 0) ? 8'hFF : 8'($urandom);
    end else if (pick < 10) begin
      d.read_ok = 1'b0;
      if ($urandom_range(1) == 0) d.full_length = 1'($urandom);
      if ($urandom_range(1) == 0) d.header_byte = 8'($urandom);
    end else if (pick < 10 + bad_pct) begin
      case ($urandom_range(2))
        0: d.full_length = 1'b0;
        1: begin
          hdr = 8'($urandom);
          d.header_byte = (hdr == 8'hFF) ? 8'hFE : hdr;
        end
        default: begin
          d.full_length = 1'b0;
          d.header_byte = 8'($urandom);
        end
      endcase
      if ($urandom_range(2) == 0) d.sum_byte = 8'($urandom);
    end else if (pick < 20 + bad_pct) begin
      d.sum_byte = d.sum_byte + 8'($urandom_range(1, 255));
    end
    return d;
  endfunction

  task automatic send_reply(input tpcs_in_t d);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_e idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[12:0];
    @(posedge clk);
    sb.set_reg(idx, val[12:0]);
  endtask

  task automatic load_config(input int pitch_b, input int roll_b, input int limit);
    drain();
    repeat (SettleCycles) @(posedge clk);
    write_reg(CFG_PITCH_BIAS, pitch_b);
    write_reg(CFG_ROLL_BIAS, roll_b);
    write_reg(CFG_ERROR_LIMIT, limit);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count, input int bad_pct, input int hold_at,
                            input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        pause_sender(($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12));
      end
      send_reply(make_reply(bad_pct));
      burst_left--;
    end
  endtask

  initial begin
    sb          = new();
    hold_req    = 1'b0;
    idle_cycles = 0;
    burst_left  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: angle extremes, checksum, failed read, bad frames.
    send_reply(good_frame(8'h00, 8'h00, 8'h00, 8'h00));
    send_reply(good_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_reply(good_frame(8'h80, 8'h00, 8'h80, 8'h00));
    send_reply(good_frame(8'h7F, 8'hFF, 8'h80, 8'h01));
    send_reply(good_frame(8'h00, 8'h01, 8'hFF, 8'hFE));
    send_reply(make_frame(1'b1, 1'b1, 8'hFF, 8'h10, 8'h20, 8'h30, 8'h40, 8'h00));
    send_reply(make_frame(1'b1, 1'b1, 8'hFF, 8'h10, 8'h20, 8'h30, 8'h40, 8'hA1));
    send_reply(make_frame(1'b0, 1'b1, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h0A));
    send_reply(make_frame(1'b0, 1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_reply(make_frame(1'b1, 1'b1, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h14));
    send_reply(make_frame(1'b1, 1'b1, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_reply(make_frame(1'b1, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_reply(make_frame(1'b1, 1'b0, 8'h7F, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hFE));
    send_reply(good_frame(8'h12, 8'h34, 8'hAB, 8'hCD));
    run_random(250, 15, 120, -1);

    // Extreme biases, error limit of one: every second bad frame requests a reset.
    load_config(-2560, 2560, 1);
    send_reply(make_frame(1'b1, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_reply(make_frame(1'b1, 1'b1, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_reply(make_frame(1'b1, 1'b1, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_reply(make_frame(1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_reply(good_frame(8'hFF, 8'hFF, 8'h00, 8'h00));
    send_reply(make_frame(1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_reply(good_frame(8'h00, 8'h00, 8'hFF, 8'hFF));
    send_reply(make_frame(1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    run_random(250, 15, -1, -1);

    load_config(2560, -2560, 63);
    run_random(300, 55, -1, 150);

    // Zero limit: every bad frame asks for a sensor reset.
    load_config(0, 0, 0);
    run_random(200, 40, -1, -1);

    load_config($urandom_range(5120) - 2560, $urandom_range(5120) - 2560,
                $urandom_range(1, 63));
    run_random(300, 15, -1, -1);

    load_config($urandom_range(5120) - 2560, $urandom_range(5120) - 2560,
                $urandom_range(1, 8));
    run_random(300, 50, -1, -1);

    load_config(-192, 38, 30);
    run_random(300, 20, -1, -1);

    drain();
    repeat (SettleCycles * 2) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/tpcs_pkg.sv
sv/tpcs_front.sv
sv/tpcs_fifo.sv
sv/tpcs_back.sv
sv/tilt_packet_check_and_scale_unit.sv
tb/tb.sv
